### rtl/csv_field_text_normalizer_defines.svh
// Assertion macros shared by the normalizer RTL.
`ifndef CSV_FIELD_TEXT_NORMALIZER_DEFINES_SVH
`define CSV_FIELD_TEXT_NORMALIZER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CFN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("cfn assertion failed");

// Next-cycle implication, checked out of reset.
`define CFN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("cfn assertion failed");

`endif

### rtl/cfn_pkg.sv
`timescale 1ns / 1ps
package cfn_pkg;

  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChSemi  = 8'h3B;

  // Results of one input byte, handed to the output buffer.
  typedef struct packed {
    logic       load;
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } pkt_t;

endpackage

### rtl/cfn_ifs.sv
`timescale 1ns / 1ps
interface cfn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface cfn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

### rtl/cfn_norm_stage.sv
`timescale 1ns / 1ps
`include "csv_field_text_normalizer_defines.svh"
module cfn_norm_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  cfn_in_if.sink        in_i,
  input  logic          free_i,
  output cfn_pkg::pkt_t pkt_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       comma_owed_q, comma_owed_d;
  logic       started_q, started_d;
  logic       run_open_q, run_open_d;
  logic       hard_q, hard_d;
  logic       semi_q, semi_d;

  logic is_lf, is_comma, is_quote, is_ws, is_hard;
  logic k_comma, k_space, k_byte, has, move;
  logic [7:0] byte2;

  assign is_lf    = (byte_q == cfn_pkg::ChLf);
  assign is_comma = (byte_q == cfn_pkg::ChComma);
  assign is_quote = (byte_q == cfn_pkg::ChQuote);
  assign is_hard  = (byte_q == cfn_pkg::ChVt) || (byte_q == cfn_pkg::ChFf);
  assign is_ws    = is_hard || (byte_q == cfn_pkg::ChSpace) ||
                    (byte_q == cfn_pkg::ChTab) || (byte_q == cfn_pkg::ChCr);

  always_comb begin
    k_comma      = 1'b0;
    k_space      = 1'b0;
    k_byte       = 1'b0;
    comma_owed_d = comma_owed_q;
    started_d    = started_q;
    run_open_d   = run_open_q;
    hard_d       = hard_q;
    semi_d       = semi_q;
    if (is_lf) begin
      k_space      = run_open_q && hard_q;
      k_byte       = 1'b1;
      comma_owed_d = 1'b0;
      started_d    = 1'b0;
      run_open_d   = 1'b0;
      hard_d       = 1'b0;
      semi_d       = 1'b0;
    end else begin
      k_comma      = comma_owed_q;
      comma_owed_d = 1'b0;
      if (is_comma) begin
        k_space      = run_open_q && hard_q;
        comma_owed_d = 1'b1;
        started_d    = 1'b0;
        run_open_d   = 1'b0;
        hard_d       = 1'b0;
        semi_d       = 1'b0;
      end else if (is_quote) begin
        k_space = 1'b0;
      end else if (is_ws) begin
        run_open_d = 1'b1;
        hard_d     = hard_q || is_hard;
      end else begin
        k_space    = run_open_q ? (started_q || hard_q) : semi_q;
        k_byte     = 1'b1;
        started_d  = 1'b1;
        semi_d     = (byte_q == cfn_pkg::ChSemi);
        run_open_d = 1'b0;
        hard_d     = 1'b0;
      end
    end
  end

  assign byte2 = byte_q;
  assign has   = k_comma || k_space || k_byte;
  assign move  = valid_q && (free_i || !has);

  always_comb begin
    pkt_o.load = move && has;
    pkt_o.two  = (k_comma && k_space) || (k_comma && k_byte) || (k_space && k_byte);
    pkt_o.b0   = k_comma ? cfn_pkg::ChComma : (k_space ? cfn_pkg::ChSpace : byte2);
    pkt_o.b1   = (k_comma && k_space) ? cfn_pkg::ChSpace : byte2;
  end

  assign in_i.ready = !valid_q || move;
  assign valid_d    = (in_i.valid && in_i.ready) ? 1'b1 : (move ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      comma_owed_q <= 1'b0;
      started_q    <= 1'b0;
      run_open_q   <= 1'b0;
      hard_q       <= 1'b0;
      semi_q       <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (move) begin
        comma_owed_q <= comma_owed_d;
        started_q    <= started_d;
        run_open_q   <= run_open_d;
        hard_q       <= hard_d;
        semi_q       <= semi_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.in_byte;
    end
  end

  `CFN_ASSERT_IMP(a_owed_field_clear, clk_i, rst_ni, comma_owed_q, !started_q && !run_open_q)
  `CFN_ASSERT_IMP(a_semi_started, clk_i, rst_ni, semi_q, started_q)
  `CFN_ASSERT_IMP(a_hard_in_run, clk_i, rst_ni, hard_q, run_open_q)
  `CFN_ASSERT_IMP(a_load_needs_free, clk_i, rst_ni, pkt_o.load, free_i)

endmodule

### rtl/cfn_out_buf.sv
`timescale 1ns / 1ps
`include "csv_field_text_normalizer_defines.svh"
module cfn_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfn_pkg::pkt_t pkt_i,
  output logic          free_o,
  cfn_out_if.source     out_o
);

  logic       valid_q;
  logic       two_q;
  logic       pos_q;
  logic [7:0] b0_q, b1_q;
  logic       fire, last;

  assign fire   = valid_q && out_o.ready;
  assign last   = pos_q || !two_q;
  assign free_o = !valid_q || (fire && last);

  assign out_o.valid    = valid_q;
  assign out_o.out_byte = pos_q ? b1_q : b0_q;
  assign out_o.run_last = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= 1'b0;
      two_q   <= 1'b0;
    end else if (pkt_i.load) begin
      valid_q <= 1'b1;
      pos_q   <= 1'b0;
      two_q   <= pkt_i.two;
    end else if (fire && last) begin
      valid_q <= 1'b0;
      pos_q   <= 1'b0;
    end else if (fire) begin
      pos_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_i.load) begin
      b0_q <= pkt_i.b0;
      b1_q <= pkt_i.b1;
    end
  end

  `CFN_ASSERT_IMP(a_pos_in_pair, clk_i, rst_ni, pos_q, valid_q && two_q)
  `CFN_ASSERT_NXT(a_second_follows, clk_i, rst_ni, fire && !last && !pkt_i.load,
                  valid_q && pos_q)
  `CFN_ASSERT_IMP(a_load_when_free, clk_i, rst_ni, pkt_i.load, free_o)

endmodule

### rtl/csv_field_text_normalizer.sv
`timescale 1ns / 1ps
// CSV field normalizer: takes one text byte per transaction and returns zero, one or two
// normalized bytes, with run_last marking the final byte caused by each input byte. An input
// byte is registered, decoded against the field state, and its results are loaded into a
// two-byte output buffer, from which the first result is presented once it is loaded. Input
// bytes that cause at most one result flow at one per cycle while the output port takes
// every byte; a byte that causes two holds the one-byte output port for both of its bytes,
// so the sustained rate is set by the output port. Bytes that cause no result never wait
// on the output side.
module csv_field_text_normalizer (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfn_in_if.sink    in_i,
  cfn_out_if.source out_o
);

  cfn_pkg::pkt_t pkt;
  logic          free;

  cfn_norm_stage u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .free_i (free),
    .pkt_o  (pkt)
  );

  cfn_out_buf u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pkt_i  (pkt),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule
